@@ rtl/ami_line_code_frame_generator_assert.svh @@
`ifndef AMI_LINE_CODE_FRAME_GENERATOR_ASSERT_SVH
`define AMI_LINE_CODE_FRAME_GENERATOR_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define AMI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ami line code check failed");

// Next-cycle implication, masked while reset is high.
`define AMI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ami line code check failed");

// Next-cycle implication that also covers the reset cycles.
`define AMI_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ami line code check failed");

`endif

@@ rtl/ami_lcfg_pkg.sv @@
package ami_lcfg_pkg;

  // Frame geometry
  localparam int unsigned SEQ_LEN   = 32;
  localparam int unsigned HALF_BITS = 2 * SEQ_LEN;
  localparam int unsigned HBI_W     = 6;
  localparam int unsigned BIT_W     = 5;

  // Segment codes as seen on the output
  typedef enum logic [1:0] {
    SEG_SYNC_HIGH = 2'd0,
    SEG_SYNC_LOW  = 2'd1,
    SEG_SYNC_ZERO = 2'd2,
    SEG_DATA      = 2'd3
  } segment_t;

  // Register word indexes
  typedef enum logic [2:0] {
    REG_DATA_BITS  = 3'd0,
    REG_SYNC_TICKS = 3'd1,
    REG_HALF_TICKS = 3'd2,
    REG_ZERO_LVL   = 3'd3,
    REG_PLUS_LVL   = 3'd4,
    REG_MINUS_LVL  = 3'd5,
    REG_SHIGH_LVL  = 3'd6,
    REG_SLOW_LVL   = 3'd7
  } reg_index_t;

  // Register reset values
  localparam logic [31:0] RST_DATA_BITS  = 32'hAAAA_AAAA;
  localparam logic [15:0] RST_SYNC_TICKS = 16'd20;
  localparam logic [15:0] RST_HALF_TICKS = 16'd10;
  localparam logic [7:0]  RST_ZERO_LVL   = 8'd130;
  localparam logic [7:0]  RST_PLUS_LVL   = 8'd150;
  localparam logic [7:0]  RST_MINUS_LVL  = 8'd110;
  localparam logic [7:0]  RST_SHIGH_LVL  = 8'd255;
  localparam logic [7:0]  RST_SLOW_LVL   = 8'd0;

endpackage

@@ rtl/ami_line_code_frame_generator.sv @@
// AMI return-to-zero frame generator. Every input beat is one time tick
// (s_tdata: bit 0 advance, bit 1 restart) and yields exactly one output beat
// with the DAC code (m_tdata), the segment code (m_tuser: 0 sync high, 1 sync
// low, 2 sync zero, 3 data) and m_tlast on the last advancing tick of a frame.
// A frame is the three-level sync preamble of sync_ticks each, then 32 data
// bits of two half-bits of half_bit_ticks each; marks alternate polarity and
// every frame starts with a plus mark. One beat is taken per clock: the frame
// position update is one pass of logic into the output register, and the
// input stalls only while that register holds a result not yet taken.
// Registers sit on the APB port at byte offset 4*i; write them only while
// the stream is idle.
module ami_line_code_frame_generator (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] advance, [1] restart, [7:2] zero
  // stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] line_level
  output logic [1:0]  m_tuser,   // [1:0] segment
  output logic        m_tlast,   // frame_end
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ami_lcfg_pkg::*;

  // Configuration registers
  logic [31:0] data_bits;
  logic [15:0] sync_ticks;
  logic [15:0] half_bit_ticks;
  logic [7:0]  rz_level;
  logic [7:0]  plus_level;
  logic [7:0]  minus_level;
  logic [7:0]  sync_high_level;
  logic [7:0]  sync_low_level;

  // Frame position
  segment_t         segment_reg, segment_next;
  logic [15:0]      tick_count, tick_count_next;
  logic [HBI_W-1:0] half_bit_index, half_bit_index_next;
  logic             last_mark_plus, last_mark_plus_next;

  logic             advance, restart, in_beat;
  segment_t         seg_cur;
  logic [15:0]      tick_cur;
  logic [HBI_W-1:0] hbi_cur;
  logic [BIT_W-1:0] bit_sel;
  logic             lmp_cur;
  logic [15:0]      dur;
  logic             level_done, mark_half;
  logic [7:0]       level;
  logic             frame_end;
  reg_index_t       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_index_t'(paddr[4:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      data_bits       <= RST_DATA_BITS;
      sync_ticks      <= RST_SYNC_TICKS;
      half_bit_ticks  <= RST_HALF_TICKS;
      rz_level        <= RST_ZERO_LVL;
      plus_level      <= RST_PLUS_LVL;
      minus_level     <= RST_MINUS_LVL;
      sync_high_level <= RST_SHIGH_LVL;
      sync_low_level  <= RST_SLOW_LVL;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_DATA_BITS:  data_bits       <= pwdata;
        REG_SYNC_TICKS: sync_ticks      <= pwdata[15:0];
        REG_HALF_TICKS: half_bit_ticks  <= pwdata[15:0];
        REG_ZERO_LVL:   rz_level        <= pwdata[7:0];
        REG_PLUS_LVL:   plus_level      <= pwdata[7:0];
        REG_MINUS_LVL:  minus_level     <= pwdata[7:0];
        REG_SHIGH_LVL:  sync_high_level <= pwdata[7:0];
        REG_SLOW_LVL:   sync_low_level  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      REG_DATA_BITS:  prdata = data_bits;
      REG_SYNC_TICKS: prdata = {16'd0, sync_ticks};
      REG_HALF_TICKS: prdata = {16'd0, half_bit_ticks};
      REG_ZERO_LVL:   prdata = {24'd0, rz_level};
      REG_PLUS_LVL:   prdata = {24'd0, plus_level};
      REG_MINUS_LVL:  prdata = {24'd0, minus_level};
      REG_SHIGH_LVL:  prdata = {24'd0, sync_high_level};
      REG_SLOW_LVL:   prdata = {24'd0, sync_low_level};
      default:        prdata = 32'd0;
    endcase
  end

  assign advance  = s_tdata[0];
  assign restart  = s_tdata[1];
  assign s_tready = !m_tvalid || m_tready;
  assign in_beat  = s_tvalid && s_tready;

  // Apply restart before anything else
  assign seg_cur  = restart ? SEG_SYNC_HIGH : segment_reg;
  assign tick_cur = restart ? 16'd0 : tick_count;
  assign hbi_cur  = restart ? '0 : half_bit_index;
  assign lmp_cur  = restart ? 1'b0 : last_mark_plus;

  assign bit_sel   = hbi_cur[HBI_W-1:1];
  assign mark_half = !hbi_cur[0] && data_bits[bit_sel];

  // Level of the current tick
  always_comb begin
    unique case (seg_cur)
      SEG_SYNC_HIGH: level = sync_high_level;
      SEG_SYNC_LOW:  level = sync_low_level;
      SEG_SYNC_ZERO: level = rz_level;
      SEG_DATA:      level = mark_half ? (lmp_cur ? minus_level : plus_level) : rz_level;
      default:       level = rz_level;
    endcase
  end

  // Duration of the current level, zero counts as one
  always_comb begin
    dur = (seg_cur == SEG_DATA) ? half_bit_ticks : sync_ticks;
    if (dur == 16'd0) dur = 16'd1;
  end

  assign level_done = ({1'b0, tick_cur} + 17'd1) >= {1'b0, dur};

  // Advance the frame position by one tick
  always_comb begin
    segment_next        = seg_cur;
    tick_count_next     = tick_cur;
    half_bit_index_next = hbi_cur;
    last_mark_plus_next = lmp_cur;
    frame_end           = 1'b0;
    if (advance) begin
      if (level_done) begin
        tick_count_next = 16'd0;
        if (seg_cur != SEG_DATA) begin
          segment_next = segment_t'(seg_cur + 2'd1);
          half_bit_index_next = '0;
        end else begin
          if (mark_half) last_mark_plus_next = !lmp_cur;
          if ({1'b0, hbi_cur} + (HBI_W+1)'(1) >= (HBI_W+1)'(HALF_BITS)) begin
            frame_end           = 1'b1;
            segment_next        = SEG_SYNC_HIGH;
            half_bit_index_next = '0;
            last_mark_plus_next = 1'b0;
          end else begin
            half_bit_index_next = hbi_cur + HBI_W'(1);
          end
        end
      end else begin
        tick_count_next = tick_cur + 16'd1;
      end
    end
  end

  // Hold the frame position, step it on each input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_reg    <= SEG_SYNC_HIGH;
      tick_count     <= 16'd0;
      half_bit_index <= '0;
      last_mark_plus <= 1'b0;
    end else if (in_beat) begin
      segment_reg    <= segment_next;
      tick_count     <= tick_count_next;
      half_bit_index <= half_bit_index_next;
      last_mark_plus <= last_mark_plus_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_beat) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      m_tdata <= level;
      m_tuser <= seg_cur;
      m_tlast <= frame_end;
    end
  end

endmodule

@@ rtl/ami_lcfg_checker.sv @@
`include "ami_line_code_frame_generator_assert.svh"

module ami_lcfg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);
  import ami_lcfg_pkg::*;

  logic [10:0] m_payload;

  assign m_payload = {m_tlast, m_tuser, m_tdata};

  // A stalled result beat holds its payload
  `AMI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_payload))

  // Frame end only closes a data half-bit
  `AMI_ASSERT_NOW(a_last_in_data, m_tvalid && m_tlast, m_tuser == SEG_DATA)

  // No new beat enters while the output register is blocked
  `AMI_ASSERT_NOW(a_stall_blocks_in, m_tvalid && !m_tready, !s_tready)

  // A restart beat shows the frame start on the next result
  `AMI_ASSERT_NEXT(a_restart_start, s_tvalid && s_tready && s_tdata[1], m_tvalid && m_tuser == SEG_SYNC_HIGH)

  // Reset empties the output register and opens the input
  `AMI_ASSERT_NEXT_ALWAYS(a_reset_clear, rst, !m_tvalid && s_tready)

endmodule

bind ami_line_code_frame_generator ami_lcfg_checker u_ami_lcfg_checker (.*);
